>>> design/tcs_pkg.sv
// shared types, constants and helpers of the transient class scorer
package tcs_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_KICK       = 3'd0,
      CSR_SNARE      = 3'd1,
      CSR_HIHAT      = 3'd2,
      CSR_TONAL      = 3'd3,
      CSR_PERCUSSION = 3'd4,
      CSR_MIN_CONF   = 3'd5
   } csr_index_type;

   // result class codes
   typedef enum logic [2:0] {
      CLASS_NONE       = 3'd0,
      CLASS_KICK       = 3'd1,
      CLASS_SNARE      = 3'd2,
      CLASS_HIHAT      = 3'd3,
      CLASS_TONAL      = 3'd4,
      CLASS_PERCUSSION = 3'd5
   } class_code_type;

   localparam int unsigned NUM_TERMS = 13;
   localparam logic [16:0] ONE_Q15 = 17'd32768;

   // reciprocals of the ramp softness values, rounded to nearest
   localparam logic [26:0] R_0P2    = 27'd327680;
   localparam logic [26:0] R_0P15   = 27'd436907;
   localparam logic [26:0] R_100MS  = 27'd21474836;
   localparam logic [26:0] R_150MS  = 27'd14316558;
   localparam logic [26:0] R_20MS   = 27'd107374182;
   localparam logic [26:0] R_300HZ  = 27'd7158279;
   localparam logic [26:0] R_1000HZ = 27'd2147484;

   // one ramp term before the multiply: distance outside the edge
   typedef struct packed {
      logic        hit;
      logic [16:0] gap;
      logic [26:0] recip;
   } term_req_type;

   // gates carried along the pipeline
   typedef struct packed {
      logic kick;
      logic snare;
      logic hihat;
      logic tonal;
   } gate_type;

   typedef struct packed {
      logic [63:0] kick;
      logic [63:0] snare;
      logic [31:0] hihat;
      logic [47:0] tonal;
      logic [63:0] perc;
      logic [15:0] min_conf;
   } csr_type;

   function automatic logic [15:0] slice16(input logic [63:0] r, input int unsigned k);
      slice16 = r[16*k +: 16];
   endfunction

   // distance outside a lower edge
   function automatic term_req_type above_req(input logic [16:0] v, input logic [16:0] thr,
                                              input logic [26:0] rc);
      term_req_type t;
      t.hit   = (v >= thr);
      t.gap   = thr - v;
      t.recip = rc;
      above_req = t;
   endfunction

   // distance outside an upper edge
   function automatic term_req_type below_req(input logic [16:0] v, input logic [16:0] thr,
                                              input logic [26:0] rc);
      term_req_type t;
      t.hit   = (v <= thr);
      t.gap   = v - thr;
      t.recip = rc;
      below_req = t;
   endfunction

   // distance outside a range; inverted range measures below lo from lo
   function automatic term_req_type range_req(input logic [16:0] v, input logic [16:0] lo,
                                              input logic [16:0] hi, input logic [26:0] rc);
      term_req_type t;
      t.hit   = (v >= lo) && (v <= hi);
      t.gap   = (v < lo) ? (lo - v) : (v - hi);
      t.recip = rc;
      range_req = t;
   endfunction

endpackage

>>> design/tcs_terms.sv
// front stage: gates and ramp distances, then registered ramp products
module tcs_terms (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  tcs_pkg::csr_type                         csr,
   input  logic [15:0]                              b0,
   input  logic [15:0]                              b1,
   input  logic [15:0]                              b2,
   input  logic [15:0]                              b3,
   input  logic [15:0]                              flat,
   input  logic [14:0]                              cent,
   input  logic [15:0]                              decay,
   input  logic [15:0]                              attack,
   output logic                                     out_valid,
   output tcs_pkg::gate_type                        out_gate,
   output logic [tcs_pkg::NUM_TERMS-1:0][16:0]      out_term
);
   import tcs_pkg::*;

   term_req_type [NUM_TERMS-1:0] req_in, req_ff;
   gate_type                     gate_in, gate1_ff, gate2_ff;
   logic                         v1_ff, v2_ff;
   logic [NUM_TERMS-1:0][16:0]   term_in, term_ff;
   logic [16:0]                  body, kthr;

   // distances and gates
   always_comb begin
      body = {1'b0, b1} + {1'b0, b2};
      kthr = {1'b0, slice16(csr.kick, 0)};
      gate_in.kick  = ({2'b0, b0} * 19'd5) >= ({2'b0, kthr[15:0]} * 19'd3);
      gate_in.snare = {1'b0, b0} < kthr;
      gate_in.hihat = {b3, 1'b0} >= {1'b0, slice16(csr.hihat, 0)};
      gate_in.tonal = {1'b0, flat} <= {slice16(csr.tonal, 0), 1'b0};
      req_in[0]  = above_req({1'b0, b0}, kthr, R_0P2);
      req_in[1]  = range_req({1'b0, decay}, {1'b0, slice16(csr.kick, 1)},
                             {1'b0, slice16(csr.kick, 2)}, R_100MS);
      req_in[2]  = below_req({2'b0, cent}, {1'b0, slice16(csr.kick, 3)}, R_300HZ);
      req_in[3]  = above_req(body, {1'b0, slice16(csr.snare, 0)}, R_0P15);
      req_in[4]  = above_req({1'b0, flat}, {1'b0, slice16(csr.snare, 1)}, R_0P2);
      req_in[5]  = range_req({1'b0, decay}, {1'b0, slice16(csr.snare, 2)},
                             {1'b0, slice16(csr.snare, 3)}, R_150MS);
      req_in[6]  = above_req({1'b0, b3}, {1'b0, slice16(csr.hihat, 0)}, R_0P2);
      req_in[7]  = above_req({1'b0, flat}, {1'b0, slice16(csr.hihat, 1)}, R_0P2);
      req_in[8]  = below_req({1'b0, flat}, {1'b0, slice16(csr.tonal, 0)}, R_0P2);
      req_in[9]  = range_req({1'b0, attack}, {1'b0, slice16(csr.tonal, 1)},
                             {1'b0, slice16(csr.tonal, 2)}, R_20MS);
      req_in[10] = above_req(body, {1'b0, slice16(csr.perc, 0)}, R_0P2);
      req_in[11] = range_req({1'b0, decay}, {1'b0, slice16(csr.perc, 1)},
                             {1'b0, slice16(csr.perc, 2)}, R_150MS);
      req_in[12] = below_req({2'b0, cent}, {1'b0, slice16(csr.perc, 3)}, R_1000HZ);
   end

   // ramp products: one 17x27 multiply per term
   always_comb begin
      logic [43:0] prod;
      for (int i = 0; i < NUM_TERMS; i++) begin
         prod = {27'b0, req_ff[i].gap} * {17'b0, req_ff[i].recip};
         if (req_ff[i].hit)
            term_in[i] = ONE_Q15;
         else if (prod[43:16] >= {11'b0, ONE_Q15})
            term_in[i] = 17'd0;
         else
            term_in[i] = ONE_Q15 - prod[32:16];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff   <= req_in;
         gate1_ff <= gate_in;
         term_ff  <= term_in;
         gate2_ff <= gate1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_gate  = gate2_ff;
   assign out_term  = term_ff;
endmodule

>>> design/tcs_select.sv
// back stages: class means, then best class and confidence
module tcs_select (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  tcs_pkg::gate_type                        gate,
   input  logic [tcs_pkg::NUM_TERMS-1:0][16:0]      term,
   input  logic [15:0]                              min_conf,
   output logic                                     out_valid,
   output logic [2:0]                               class_code,
   output logic [15:0]                              confidence
);
   import tcs_pkg::*;

   logic [4:0][16:0] score_in, score_ff;
   logic             v3_ff, v4_ff;
   logic [2:0]       code_in, code_ff;
   logic [15:0]      conf_in, conf_ff;
   logic [18:0]      s_kick, s_snare, s_perc;
   logic [17:0]      s_hihat, s_tonal;

   // divide by three through reciprocal multiply (sum < 98305)
   function automatic logic [16:0] div3(input logic [18:0] s);
      logic [37:0] p;
      p = {19'b0, s} * 38'd174763;
      div3 = p[35:19];
   endfunction

   // class means, gated for every class but percussion
   always_comb begin
      s_kick  = {2'b0, term[0]} + {2'b0, term[1]} + {2'b0, term[2]};
      s_snare = {2'b0, term[3]} + {2'b0, term[4]} + {2'b0, term[5]};
      s_hihat = {1'b0, term[6]} + {1'b0, term[7]};
      s_tonal = {1'b0, term[8]} + {1'b0, term[9]};
      s_perc  = {2'b0, term[10]} + {2'b0, term[11]} + {2'b0, term[12]};
      score_in[0] = gate.kick  ? div3(s_kick)  : 17'd0;
      score_in[1] = gate.snare ? div3(s_snare) : 17'd0;
      score_in[2] = gate.hihat ? s_hihat[17:1] : 17'd0;
      score_in[3] = gate.tonal ? s_tonal[17:1] : 17'd0;
      score_in[4] = div3(s_perc);
   end

   // first strict maximum wins
   always_comb begin
      logic [16:0] best;
      logic [2:0]  idx;
      best = 17'd0;
      idx  = CLASS_NONE;
      for (int i = 0; i < 5; i++) begin
         if (score_ff[i] > best) begin
            best = score_ff[i];
            idx  = 3'(i + 1);
         end
      end
      if (best >= {1'b0, min_conf}) begin
         code_in = idx;
         conf_in = best[15:0];
      end else begin
         code_in = CLASS_NONE;
         conf_in = 16'(ONE_Q15 - best);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= in_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         score_ff <= score_in;
         code_ff  <= code_in;
         conf_ff  <= conf_in;
      end
   end

   assign out_valid  = v4_ff;
   assign class_code = code_ff;
   assign confidence = conf_ff;
endmodule

>>> design/transient_class_scorer_top.sv
// top level of the transient class scorer
// throughput: one item per cycle; the four-stage pipeline moves whenever
// its last stage is empty or its result is taken
// reset clears all valid bits and the configuration registers to zero
module transient_class_scorer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_band_low_ratio,
   input  logic [15:0] req_band_lowmid_ratio,
   input  logic [15:0] req_band_highmid_ratio,
   input  logic [15:0] req_band_high_ratio,
   input  logic [15:0] req_flatness,
   input  logic [14:0] req_centroid_hz,
   input  logic [15:0] req_decay_ms,
   input  logic [15:0] req_attack_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_class_code,
   output logic [15:0] rsp_confidence
);
   import tcs_pkg::*;

   csr_type                    csr_ff;
   logic                       adv, mid_valid;
   gate_type                   mid_gate;
   logic [NUM_TERMS-1:0][16:0] mid_term;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KICK:       csr_ff.kick     <= csr_data;
            CSR_SNARE:      csr_ff.snare    <= csr_data;
            CSR_HIHAT:      csr_ff.hihat    <= csr_data[31:0];
            CSR_TONAL:      csr_ff.tonal    <= csr_data[47:0];
            CSR_PERCUSSION: csr_ff.perc     <= csr_data;
            CSR_MIN_CONF:   csr_ff.min_conf <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless a held result is stalled
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   tcs_terms u_terms (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid), .csr(csr_ff),
      .b0(req_band_low_ratio), .b1(req_band_lowmid_ratio),
      .b2(req_band_highmid_ratio), .b3(req_band_high_ratio),
      .flat(req_flatness), .cent(req_centroid_hz), .decay(req_decay_ms),
      .attack(req_attack_ms), .out_valid(mid_valid), .out_gate(mid_gate),
      .out_term(mid_term)
   );

   tcs_select u_select (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(mid_valid), .gate(mid_gate),
      .term(mid_term), .min_conf(csr_ff.min_conf), .out_valid(rsp_valid),
      .class_code(rsp_class_code), .confidence(rsp_confidence)
   );
endmodule

>>> design/tcs_checker.sv
// port-level checks of the transient class scorer, bound to the top level
module tcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_class_code,
   input logic [15:0] rsp_confidence
);
   import tcs_pkg::*;

   // input stalls only while a result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_class_code)
                                    && $stable(rsp_confidence)))
      else $error("stalled result changed");

   // class code within range
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_class_code <= CLASS_PERCUSSION))
      else $error("bad class code");

   // confidence never above one
   a_conf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_confidence <= 16'd32768))
      else $error("confidence above one");

   // an item accepted without a stall appears as a valid result if the receiver does not stall in between
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after latency");
endmodule

bind transient_class_scorer_top tcs_checker u_tcs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_class_code(rsp_class_code),
   .rsp_confidence(rsp_confidence)
);

>>> tb/sv/transient_class_scorer_top_tb.sv
// self-checking testbench of the transient class scorer: predicts class and confidence per item
module transient_class_scorer_top_tb;
   import tcs_pkg::*;

   typedef struct {
      logic [15:0] b0, b1, b2, b3, flat;
      logic [14:0] cent;
      logic [15:0] decay, attack;
   } onset_type;

   typedef struct {
      class_code_type code;
      logic [15:0]    conf;
   } verdict_type;

   int error_count = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   // configuration copy and expected verdict queue
   class verdict_board;
      logic [63:0] kick_cfg, snare_cfg, perc_cfg;
      logic [31:0] hihat_cfg;
      logic [47:0] tonal_cfg;
      logic [15:0] min_conf;
      verdict_type pending[$];

      function new();
         kick_cfg = 0; snare_cfg = 0; perc_cfg = 0; hihat_cfg = 0; tonal_cfg = 0;
         min_conf = 0;
      endfunction

      function void set_reg(input csr_index_type idx, input logic [63:0] v);
         case (idx)
            CSR_KICK:       kick_cfg = v;
            CSR_SNARE:      snare_cfg = v;
            CSR_HIHAT:      hihat_cfg = v[31:0];
            CSR_TONAL:      tonal_cfg = v[47:0];
            CSR_PERCUSSION: perc_cfg = v;
            CSR_MIN_CONF:   min_conf = v[15:0];
            default: ;
         endcase
      endfunction

      // linear falloff outside an edge
      function longint unsigned falloff(input longint unsigned d, input longint unsigned r);
         longint unsigned p;
         p = (d * r) >> 16;
         return (p >= 32768) ? 0 : 32768 - p;
      endfunction

      function longint unsigned at_least(input longint unsigned v, thr, r);
         return (v >= thr) ? 32768 : falloff(thr - v, r);
      endfunction

      function longint unsigned at_most(input longint unsigned v, thr, r);
         return (v <= thr) ? 32768 : falloff(v - thr, r);
      endfunction

      function longint unsigned within_span(input longint unsigned v, lo, hi, r);
         if (v >= lo && v <= hi) return 32768;
         if (v < lo) return falloff(lo - v, r);
         return falloff(v - hi, r);
      endfunction

      function longint unsigned fld(input logic [63:0] r, input int k);
         return r[16*k +: 16];
      endfunction

      function void note_onset(input onset_type o);
         longint unsigned s[5];
         longint unsigned body, kthr, best_score;
         int best;
         verdict_type v;
         body = o.b1 + o.b2;
         kthr = fld(kick_cfg, 0);
         s = '{default: 0};
         if (5 * longint'(o.b0) >= 3 * kthr)
            s[0] = (at_least(o.b0, kthr, 327680)
                  + within_span(o.decay, fld(kick_cfg, 1), fld(kick_cfg, 2), 21474836)
                  + at_most(o.cent, fld(kick_cfg, 3), 7158279)) / 3;
         if (o.b0 < kthr)
            s[1] = (at_least(body, fld(snare_cfg, 0), 436907)
                  + at_least(o.flat, fld(snare_cfg, 1), 327680)
                  + within_span(o.decay, fld(snare_cfg, 2), fld(snare_cfg, 3), 14316558)) / 3;
         if (2 * longint'(o.b3) >= fld(hihat_cfg, 0))
            s[2] = (at_least(o.b3, fld(hihat_cfg, 0), 327680)
                  + at_least(o.flat, fld(hihat_cfg, 1), 327680)) >> 1;
         if (o.flat <= 2 * fld(tonal_cfg, 0))
            s[3] = (at_most(o.flat, fld(tonal_cfg, 0), 327680)
                  + within_span(o.attack, fld(tonal_cfg, 1), fld(tonal_cfg, 2), 107374182)) >> 1;
         s[4] = (at_least(body, fld(perc_cfg, 0), 327680)
               + within_span(o.decay, fld(perc_cfg, 1), fld(perc_cfg, 2), 14316558)
               + at_most(o.cent, fld(perc_cfg, 3), 2147484)) / 3;
         best = 0; best_score = 0;
         for (int i = 0; i < 5; i++)
            if (s[i] > best_score) begin
               best_score = s[i];
               best = i + 1;
            end
         if (best_score >= min_conf) begin
            v.code = class_code_type'(best);
            v.conf = best_score[15:0];
         end else begin
            v.code = CLASS_NONE;
            v.conf = 16'(32768 - best_score);
         end
         pending.push_back(v);
      endfunction

      task check_verdict(input logic [2:0] code, input logic [15:0] conf);
         verdict_type v;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result class %0d", code));
            return;
         end
         v = pending.pop_front();
         if (code !== v.code)
            report_mismatch($sformatf("class %0d, want %0d", code, v.code));
         if (conf !== v.conf)
            report_mismatch($sformatf("confidence %0d, want %0d", conf, v.conf));
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [63:0] csr_data = 0;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   logic [15:0] req_band_low_ratio = 0, req_band_lowmid_ratio = 0;
   logic [15:0] req_band_highmid_ratio = 0, req_band_high_ratio = 0, req_flatness = 0;
   logic [14:0] req_centroid_hz = 0;
   logic [15:0] req_decay_ms = 0, req_attack_ms = 0;
   logic [2:0] rsp_class_code;
   logic [15:0] rsp_confidence;

   verdict_board board = new();
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;
   longint cycles = 0;

   transient_class_scorer_top u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result sampling
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict(rsp_class_code, rsp_confidence);

   // receiver stalls
   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle);

   // one register write, then the write port is left idle
   task automatic write_reg(input csr_index_type idx, input logic [63:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
   endtask

   task automatic send_onset(input onset_type o);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_band_low_ratio <= o.b0;
      req_band_lowmid_ratio <= o.b1;
      req_band_highmid_ratio <= o.b2;
      req_band_high_ratio <= o.b3;
      req_flatness <= o.flat;
      req_centroid_hz <= o.cent;
      req_decay_ms <= o.decay;
      req_attack_ms <= o.attack;
      do @(posedge clock); while (req_stall);
      board.note_onset(o);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [15:0] q15_pick();
      case ($urandom_range(5))
         0: return 0;
         1: return 32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   function automatic logic [15:0] ms_pick();
      return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600));
   endfunction

   function automatic onset_type random_onset();
      onset_type o;
      o.b0 = q15_pick(); o.b1 = q15_pick(); o.b2 = q15_pick(); o.b3 = q15_pick();
      o.flat = q15_pick();
      o.cent = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(24000));
      o.decay = ms_pick();
      o.attack = ms_pick();
      return o;
   endfunction

   // settings: realistic ranges, fully random words (which may invert ranges) and all ones
   function automatic logic [63:0] random_setting();
      case ($urandom_range(4))
         0: return 64'hFFFF_FFFF_FFFF_FFFF;
         1: return {$urandom, $urandom};
         default: return {16'($urandom_range(6000)), 16'($urandom_range(600)),
                          16'($urandom_range(300)), 16'($urandom_range(32768))};
      endcase
   endfunction

   task automatic configure_all();
      write_reg(CSR_KICK, random_setting());
      write_reg(CSR_SNARE, random_setting());
      write_reg(CSR_HIHAT, random_setting());
      write_reg(CSR_TONAL, random_setting());
      write_reg(CSR_PERCUSSION, random_setting());
      case ($urandom_range(3))
         0: write_reg(CSR_MIN_CONF, 0);
         1: write_reg(CSR_MIN_CONF, 32768);
         2: write_reg(CSR_MIN_CONF, 16'hFFFF);
         default: write_reg(CSR_MIN_CONF, $urandom_range(32768));
      endcase
   endtask

   initial begin
      onset_type o;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: reset settings, an all-zero item, extremes of fields
      o = '{0, 0, 0, 0, 0, 0, 0, 0};
      send_onset(o);
      o = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF};
      send_onset(o);
      drain();
      write_reg(CSR_KICK, {16'd150, 16'd300, 16'd50, 16'd16384});
      write_reg(CSR_SNARE, {16'd250, 16'd80, 16'd16384, 16'd19661});
      write_reg(CSR_HIHAT, {16'd16384, 16'd9830});
      write_reg(CSR_TONAL, {16'd100, 16'd10, 16'd6554});
      write_reg(CSR_PERCUSSION, {16'd3000, 16'd400, 16'd40, 16'd9830});
      write_reg(CSR_MIN_CONF, 16'd16384);
      write_reg(csr_index_type'(3'd7), 64'hDEAD);
      o = '{26000, 3000, 2000, 1000, 2000, 100, 200, 5};   // kick-like
      send_onset(o);
      o = '{2000, 12000, 10000, 6000, 24000, 3000, 100, 5}; // snare-like
      send_onset(o);
      o = '{500, 2000, 3000, 28000, 30000, 12000, 30, 2};   // hi-hat-like
      send_onset(o);
      o = '{8000, 8000, 8000, 8000, 1000, 800, 300, 30};    // tonal-like
      send_onset(o);
      o = '{16384, 16384, 16384, 16384, 16384, 24000, 0, 65535};
      send_onset(o);
      o = '{32768, 0, 32768, 0, 32768, 0, 65535, 0};
      send_onset(o);
      drain();
      write_reg(CSR_KICK, {16'd150, 16'd50, 16'd300, 16'd16384});  // inverted decay range
      write_reg(CSR_TONAL, {16'd10, 16'd100, 16'd6554});
      write_reg(CSR_MIN_CONF, 16'hFFFF);                          // unreachable
      o = '{26000, 3000, 2000, 1000, 2000, 100, 20, 50};
      send_onset(o);
      o = '{26000, 3000, 2000, 1000, 2000, 100, 200, 5};
      send_onset(o);
      drain();

      // random phases: idling pattern changes between groups of phases
      for (int ph = 0; ph < 14; ph++) begin
         configure_all();
         send_idle = (ph < 5) ? 6 : (ph < 10) ? 57 : 0;
         recv_idle = (ph < 5) ? 57 : (ph < 10) ? 6 : 0;
         if (ph == 11)
            fork
               begin
                  hold_off = 1;
                  repeat (60) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         for (int n = 0; n < 100; n++) begin
            send_onset(random_onset());
            if (n == 50) drain();
         end
         drain();
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
